// ----- rtl/assert_macros.svh -----
// Shared assertion forms for the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked from the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/gdes_pkg.sv -----
`default_nettype none
package gdes_pkg;

    localparam int NUM_EVENTS  = 88;
    localparam int DEME_EVENTS = 44;
    localparam int NUM_DIVS    = 12;

    localparam logic [5:0] EV_PAR_DEMO = 6'd4;
    localparam logic [5:0] EV_INFECT   = 6'd8;
    localparam logic [5:0] EV_HOST_MIG = 6'd24;
    localparam logic [5:0] EV_PAR_MIG  = 6'd32;
    localparam logic [5:0] EV_HOST_MUT = 6'd40;
    localparam logic [5:0] EV_PAR_MUT  = 6'd42;

    localparam logic REQ_RESET = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    localparam logic [2:0] CFG_HOST_CAP  = 3'd0;
    localparam logic [2:0] CFG_PAR_CAP   = 3'd1;
    localparam logic [2:0] CFG_INFECT    = 3'd2;
    localparam logic [2:0] CFG_MORTALITY = 3'd3;
    localparam logic [2:0] CFG_DEATH     = 3'd4;
    localparam logic [2:0] CFG_MIGRATE   = 3'd5;
    localparam logic [2:0] CFG_MUTATE    = 3'd6;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_8  = 2'd1;
    localparam logic [1:0] SH_16 = 2'd2;
    localparam logic [1:0] SH_32 = 2'd3;

    localparam logic [15:0] RESET_CAPACITY = 16'd1000;

    typedef struct packed {
        logic       take_in;
        logic       rst_counts;
        logic       div_start;
        logic [3:0] div_idx;
        logic       r_init;
        logic       mul_start;
        logic       mul_target;
        logic [6:0] ev;
        logic [2:0] step;
        logic       tot_add;
        logic       run_add;
        logic       apply;
        logic       load;
        logic       none;
    } gdes_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic is_last;
        logic total_zero;
        logic hit;
    } gdes_stat_t;

endpackage
`default_nettype wire

// ----- rtl/gdes_if.sv -----
`default_nettype none
interface gdes_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] event_draw;
    logic [15:0] host_draw_a;
    logic [15:0] host_draw_b;
    logic [15:0] host_draw_c;
    logic [15:0] parasite_draw_a;
    logic [15:0] parasite_draw_b;
    logic [15:0] parasite_draw_c;
    modport source (output valid, req_type, event_draw, host_draw_a, host_draw_b,
                    host_draw_c, parasite_draw_a, parasite_draw_b, parasite_draw_c,
                    input ready);
    modport sink (input valid, req_type, event_draw, host_draw_a, host_draw_b,
                  host_draw_c, parasite_draw_a, parasite_draw_b, parasite_draw_c,
                  output ready);
endinterface

interface gdes_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  event_index;
    logic [63:0] total_rate;
    logic        no_event;
    logic [63:0] deme0_counts;
    logic [63:0] deme1_counts;
    logic [63:0] deme0_neutral_counts;
    logic [63:0] deme1_neutral_counts;
    modport source (output valid, event_index, total_rate, no_event, deme0_counts,
                    deme1_counts, deme0_neutral_counts, deme1_neutral_counts,
                    input ready);
    modport sink (input valid, event_index, total_rate, no_event, deme0_counts,
                  deme1_counts, deme0_neutral_counts, deme1_neutral_counts,
                  output ready);
endinterface

interface gdes_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/gdes_div.sv -----
`default_nettype none
module gdes_div #(
    parameter int NW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [15:0]   den,
    output logic               done,
    output logic [NW-1:0]      quo
);
    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [15:0]     rem_reg, rem_next;
    logic [16:0]     rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, q_reg[NW-1]};
        done      = busy_reg && (cnt_reg == CNTW'(NW));
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = num;
            rem_next  = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (rem_sh >= {1'b0, den})
            begin
                rem_next = 16'(rem_sh - {1'b0, den});
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[15:0];
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quo = q_reg;
endmodule
`default_nettype wire

// ----- rtl/gdes_mul.sv -----
`default_nettype none
module gdes_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire logic [1:0]  shift,
    output logic             done,
    output logic [63:0]      result
);
    import gdes_pkg::*;

    logic [2:0]   phase_reg;
    logic         pvalid_reg;
    logic [1:0]   psh_reg;
    logic [63:0]  a_reg, b_reg;
    logic [1:0]   s_reg;
    logic [63:0]  prod_reg;
    logic [127:0] acc_reg;
    logic [31:0]  pa, pb;
    logic [1:0]   pidx;
    logic [127:0] addend, shifted;

    assign pidx = 2'(phase_reg - 3'd1);

    always_comb
    begin
        pa = pidx[1] ? a_reg[63:32] : a_reg[31:0];
        pb = pidx[0] ? b_reg[63:32] : b_reg[31:0];
        case (psh_reg)
            2'd0:    addend = {64'd0, prod_reg};
            2'd1:    addend = {32'd0, prod_reg, 32'd0};
            default: addend = {prod_reg, 64'd0};
        endcase
        case (s_reg)
            SH_0:    shifted = acc_reg;
            SH_8:    shifted = acc_reg >> 8;
            SH_16:   shifted = acc_reg >> 16;
            SH_32:   shifted = acc_reg >> 32;
            default: shifted = acc_reg;
        endcase
    end

    assign done   = (phase_reg == 3'd6);
    assign result = (|shifted[127:64]) ? '1 : shifted[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            pvalid_reg <= 1'b0;
        end
        else if (start)
        begin
            phase_reg  <= 3'd1;
            pvalid_reg <= 1'b0;
        end
        else if (phase_reg != 3'd0)
        begin
            phase_reg  <= (phase_reg == 3'd6) ? 3'd0 : phase_reg + 3'd1;
            pvalid_reg <= (phase_reg <= 3'd4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            s_reg   <= shift;
            acc_reg <= '0;
        end
        else
        begin
            if (phase_reg >= 3'd1 && phase_reg <= 3'd4)
            begin
                prod_reg <= pa * pb;
                psh_reg  <= {1'b0, pidx[1]} + {1'b0, pidx[0]};
            end
            if (pvalid_reg)
            begin
                acc_reg <= acc_reg + addend;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/gdes_dp.sv -----
`default_nettype none
module gdes_dp #(
    parameter int CW = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gdes_pkg::gdes_cmd_t  cmd,
    output gdes_pkg::gdes_stat_t      stat,
    input  wire logic [31:0]       event_draw,
    input  wire logic [15:0]       host_draw_a,
    input  wire logic [15:0]       host_draw_b,
    input  wire logic [15:0]       host_draw_c,
    input  wire logic [15:0]       parasite_draw_a,
    input  wire logic [15:0]       parasite_draw_b,
    input  wire logic [15:0]       parasite_draw_c,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    output logic [6:0]             event_index,
    output logic [63:0]            total_rate,
    output logic                   no_event,
    output logic [63:0]            deme0_counts,
    output logic [63:0]            deme1_counts,
    output logic [63:0]            deme0_neutral_counts,
    output logic [63:0]            deme1_neutral_counts
);
    import gdes_pkg::*;

    localparam int FW = CW + 16;

    function automatic logic [CW-1:0] clampc(input logic [15:0] v);
        logic [CW+15:0] w;
        w = {{CW{1'b0}}, v};
        if (|w[CW+15:CW])
            return '1;
        return w[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] adj(input logic [CW-1:0] v, input logic signed [2:0] d);
        logic signed [CW+1:0] s;
        s = $signed({2'b00, v}) + $signed({{(CW-1){d[2]}}, d});
        if (s < 0)
            return '0;
        if (s[CW])
            return '1;
        return s[CW-1:0];
    endfunction

    function automatic logic [15:0] lo16(input logic [CW-1:0] v);
        logic [CW+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    function automatic logic [63:0] coef(input logic [15:0] v);
        return {40'd0, v, 8'd0};
    endfunction

    // configuration
    logic [15:0] host_cap_reg, par_cap_reg, mort_reg;
    logic [63:0] infect_reg;
    logic [31:0] death_reg, mig_reg, mut_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_cap_reg <= RESET_CAPACITY;
            par_cap_reg  <= RESET_CAPACITY;
            infect_reg   <= '0;
            mort_reg     <= '0;
            death_reg    <= '0;
            mig_reg      <= '0;
            mut_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOST_CAP:  host_cap_reg <= cfg_data[15:0];
                CFG_PAR_CAP:   par_cap_reg  <= cfg_data[15:0];
                CFG_INFECT:    infect_reg   <= cfg_data;
                CFG_MORTALITY: mort_reg     <= cfg_data[15:0];
                CFG_DEATH:     death_reg    <= cfg_data[31:0];
                CFG_MIGRATE:   mig_reg      <= cfg_data[31:0];
                CFG_MUTATE:    mut_reg      <= cfg_data[31:0];
                default:       ;
            endcase
        end
    end

    // latched draws
    logic [31:0] edraw_reg;
    logic [15:0] ha_reg, hb_reg, hc_reg, pa_reg, pb_reg, pc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            edraw_reg <= event_draw;
            ha_reg    <= host_draw_a;
            hb_reg    <= host_draw_b;
            hc_reg    <= host_draw_c;
            pa_reg    <= parasite_draw_a;
            pb_reg    <= parasite_draw_b;
            pc_reg    <= parasite_draw_c;
        end
    end

    // counts and frequencies
    logic [CW-1:0] cnt_reg [8];
    logic [CW-1:0] ncnt_reg [8];
    logic [FW-1:0] fr_reg [8];
    logic [FW-1:0] nf_reg [4];

    // divider
    logic [CW-1:0] div_cnt;
    logic          div_par;
    logic [15:0]   div_k, div_den;
    logic [FW-1:0] div_q;

    always_comb
    begin
        if (cmd.div_idx[3])
        begin
            div_cnt = ncnt_reg[{cmd.div_idx[1], cmd.div_idx[0], 1'b0}];
            div_par = cmd.div_idx[0];
        end
        else
        begin
            div_cnt = cnt_reg[cmd.div_idx[2:0]];
            div_par = cmd.div_idx[1];
        end
        div_k   = div_par ? par_cap_reg : host_cap_reg;
        div_den = (div_k == 16'd0) ? 16'd1 : div_k;
    end

    gdes_div #(.NW(FW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({div_cnt, 16'd0}),
        .den   (div_den),
        .done  (stat.div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (stat.div_done)
        begin
            if (cmd.div_idx[3])
                nf_reg[cmd.div_idx[1:0]] <= div_q;
            else
                fr_reg[cmd.div_idx[2:0]] <= div_q;
        end
    end

    // rate operand decode
    logic       u;
    logic [5:0] x, y;
    logic [63:0] init_val, opnd;
    logic [1:0]  op_sh;
    logic [2:0]  last_step;
    logic        bi, bj;

    always_comb
    begin
        u = (cmd.ev >= 7'(DEME_EVENTS));
        x = u ? 6'(cmd.ev - 7'(DEME_EVENTS)) : cmd.ev[5:0];
        y = '0;
        bi = 1'b0;
        bj = 1'b0;
        init_val = '0;
        opnd = '0;
        op_sh = SH_0;
        last_step = '0;
        if (x < EV_PAR_DEMO)
        begin
            init_val  = coef(death_reg[15:0]);
            last_step = 3'd1;
            if (cmd.step == 3'd0)
                opnd = 64'(cnt_reg[{u, 1'b0, x[1]}]);
            else
            begin
                opnd  = 64'(fr_reg[{u, 1'b0, x[0]}]);
                op_sh = SH_16;
            end
        end
        else if (x < EV_INFECT)
        begin
            y = x - EV_PAR_DEMO;
            init_val  = coef(death_reg[31:16]);
            last_step = 3'd1;
            if (cmd.step == 3'd0)
                opnd = 64'(cnt_reg[{u, 1'b1, y[1]}]);
            else
            begin
                opnd  = 64'(fr_reg[{u, 1'b1, y[0]}]);
                op_sh = SH_16;
            end
        end
        else if (x < EV_HOST_MIG)
        begin
            y = x - EV_INFECT;
            bi = y[3];
            bj = y[2];
            init_val  = coef(mort_reg);
            last_step = 3'd4;
            case (cmd.step)
                3'd0:
                begin
                    opnd  = 64'(infect_reg[{bi, bj, 4'd0} +: 16]);
                    op_sh = SH_8;
                end
                3'd1:    opnd = 64'(cnt_reg[{u, 1'b0, bi}]);
                3'd2:    opnd = 64'(cnt_reg[{u, 1'b1, bj}]);
                3'd3:
                begin
                    opnd  = 64'(fr_reg[{u, 1'b0, y[1]}]);
                    op_sh = SH_16;
                end
                default:
                begin
                    opnd  = 64'(fr_reg[{u, 1'b1, y[0]}]);
                    op_sh = SH_16;
                end
            endcase
        end
        else if (x < EV_HOST_MUT)
        begin
            bi = (x >= EV_PAR_MIG);
            y  = bi ? x - EV_PAR_MIG : x - EV_HOST_MIG;
            init_val  = bi ? coef(mig_reg[31:16]) : coef(mig_reg[15:0]);
            last_step = 3'd2;
            case (cmd.step)
                3'd0:    opnd = 64'(cnt_reg[{u, bi, y[2]}]);
                3'd1:
                begin
                    opnd  = 64'(fr_reg[{u, bi, y[1]}]);
                    op_sh = SH_16;
                end
                default:
                begin
                    opnd  = 64'(fr_reg[{~u, bi, y[0]}]);
                    op_sh = SH_16;
                end
            endcase
        end
        else
        begin
            bi = (x >= EV_PAR_MUT);
            init_val  = bi ? coef(mut_reg[31:16]) : coef(mut_reg[15:0]);
            last_step = 3'd0;
            opnd = 64'(cnt_reg[{u, bi, x[0]}]);
        end
    end

    assign stat.is_last = (cmd.step == last_step);

    // shared multiplier
    logic [63:0] r_reg, total_reg, run_reg, tgt_reg, mul_res;

    gdes_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (cmd.mul_target ? {32'd0, edraw_reg} : r_reg),
        .b      (cmd.mul_target ? total_reg : opnd),
        .shift  (cmd.mul_target ? SH_32 : op_sh),
        .done   (stat.mul_done),
        .result (mul_res)
    );

    logic [64:0] tot_sum, run_sum;
    logic [63:0] run_next;

    assign tot_sum  = {1'b0, total_reg} + {1'b0, r_reg};
    assign run_sum  = {1'b0, run_reg} + {1'b0, r_reg};
    assign run_next = run_sum[64] ? '1 : run_sum[63:0];
    assign stat.hit = (r_reg != '0) && (run_next >= tgt_reg);
    assign stat.total_zero = (total_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            total_reg <= '0;
            run_reg   <= '0;
        end
        else
        begin
            if (cmd.tot_add)
                total_reg <= tot_sum[64] ? '1 : tot_sum[63:0];
            if (cmd.run_add)
                run_reg <= run_next;
        end
        if (cmd.r_init)
            r_reg <= init_val;
        else if (stat.mul_done && !cmd.mul_target)
            r_reg <= mul_res;
        if (stat.mul_done && cmd.mul_target)
            tgt_reg <= mul_res;
    end

    // count changes
    logic signed [2:0] d [8];
    logic signed [2:0] dn [8];
    logic [FW-1:0] fh, fp, fho, fpo;
    logic tha, thb, thc, tpa, tpb, tpc;

    always_comb
    begin
        fh  = nf_reg[{u, 1'b0}];
        fp  = nf_reg[{u, 1'b1}];
        fho = nf_reg[{~u, 1'b0}];
        fpo = nf_reg[{~u, 1'b1}];
        tha = !(FW'(ha_reg) < fh);
        thb = !(FW'(hb_reg) < fh);
        thc = !(FW'(hc_reg) < fho);
        tpa = !(FW'(pa_reg) < fp);
        tpb = !(FW'(pb_reg) < fp);
        tpc = !(FW'(pc_reg) < fpo);
        for (int i = 0; i < 8; i++)
        begin
            d[i]  = '0;
            dn[i] = '0;
        end
        if (x < EV_PAR_DEMO)
        begin
            d[{u, 1'b0, x[1]}] = d[{u, 1'b0, x[1]}] - 3'sd1;
            d[{u, 1'b0, x[0]}] = d[{u, 1'b0, x[0]}] + 3'sd1;
        end
        else if (x < EV_INFECT)
        begin
            d[{u, 1'b1, y[1]}] = d[{u, 1'b1, y[1]}] - 3'sd1;
            d[{u, 1'b1, y[0]}] = d[{u, 1'b1, y[0]}] + 3'sd1;
        end
        else if (x < EV_HOST_MIG)
        begin
            d[{u, 1'b0, y[3]}] = d[{u, 1'b0, y[3]}] - 3'sd1;
            d[{u, 1'b0, y[1]}] = d[{u, 1'b0, y[1]}] + 3'sd1;
            d[{u, 1'b1, y[2]}] = d[{u, 1'b1, y[2]}] + 3'sd1;
            d[{u, 1'b1, y[0]}] = d[{u, 1'b1, y[0]}] - 3'sd1;
        end
        else if (x < EV_HOST_MUT)
        begin
            d[{u, bi, y[2]}]  = d[{u, bi, y[2]}] - 3'sd1;
            d[{~u, bi, y[2]}] = d[{~u, bi, y[2]}] + 3'sd1;
            d[{u, bi, y[1]}]  = d[{u, bi, y[1]}] + 3'sd1;
            d[{~u, bi, y[0]}] = d[{~u, bi, y[0]}] - 3'sd1;
        end
        else
        begin
            d[{u, bi, x[0]}]  = d[{u, bi, x[0]}] - 3'sd1;
            d[{u, bi, ~x[0]}] = d[{u, bi, ~x[0]}] + 3'sd1;
        end

        if (x < EV_HOST_MIG && (x < EV_PAR_DEMO || x >= EV_INFECT))
        begin
            dn[{u, 1'b0, tha}] = dn[{u, 1'b0, tha}] + 3'sd1;
            dn[{u, 1'b0, thb}] = dn[{u, 1'b0, thb}] - 3'sd1;
        end
        if (x >= EV_PAR_DEMO && x < EV_HOST_MIG)
        begin
            dn[{u, 1'b1, tpa}] = dn[{u, 1'b1, tpa}] + 3'sd1;
            dn[{u, 1'b1, tpb}] = dn[{u, 1'b1, tpb}] - 3'sd1;
        end
        if (x >= EV_HOST_MIG && x < EV_PAR_MIG)
        begin
            dn[{u, 1'b0, tha}]  = dn[{u, 1'b0, tha}] - 3'sd1;
            dn[{~u, 1'b0, tha}] = dn[{~u, 1'b0, tha}] + 3'sd1;
            dn[{u, 1'b0, thb}]  = dn[{u, 1'b0, thb}] + 3'sd1;
            dn[{~u, 1'b0, thc}] = dn[{~u, 1'b0, thc}] - 3'sd1;
        end
        else if (x >= EV_PAR_MIG && x < EV_HOST_MUT)
        begin
            dn[{u, 1'b1, tpa}]  = dn[{u, 1'b1, tpa}] - 3'sd1;
            dn[{~u, 1'b1, tpa}] = dn[{~u, 1'b1, tpa}] + 3'sd1;
            dn[{u, 1'b1, tpb}]  = dn[{u, 1'b1, tpb}] + 3'sd1;
            dn[{~u, 1'b1, tpc}] = dn[{~u, 1'b1, tpc}] - 3'sd1;
        end
        else if (x >= EV_HOST_MUT && x < EV_PAR_MUT)
        begin
            dn[{u, 1'b0, tha}]  = dn[{u, 1'b0, tha}] - 3'sd1;
            dn[{u, 1'b0, ~tha}] = dn[{u, 1'b0, ~tha}] + 3'sd1;
        end
        else if (x >= EV_PAR_MUT)
        begin
            dn[{u, 1'b1, tpa}]  = dn[{u, 1'b1, tpa}] - 3'sd1;
            dn[{u, 1'b1, ~tpa}] = dn[{u, 1'b1, ~tpa}] + 3'sd1;
        end
    end

    logic [15:0] rh_lo, rh_hi, rp_lo, rp_hi;

    assign rh_lo = host_cap_reg >> 1;
    assign rh_hi = host_cap_reg - rh_lo;
    assign rp_lo = par_cap_reg >> 1;
    assign rp_hi = par_cap_reg - rp_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cnt_reg[i]  <= clampc(RESET_CAPACITY >> 1);
                ncnt_reg[i] <= clampc(RESET_CAPACITY - (RESET_CAPACITY >> 1));
            end
        end
        else if (cmd.rst_counts)
        begin
            for (int i = 0; i < 2; i++)
            begin
                cnt_reg[4*i]    <= clampc(rh_lo);
                cnt_reg[4*i+1]  <= clampc(rh_hi);
                cnt_reg[4*i+2]  <= clampc(rp_lo);
                cnt_reg[4*i+3]  <= clampc(rp_hi);
                ncnt_reg[4*i]   <= clampc(rh_lo);
                ncnt_reg[4*i+1] <= clampc(rh_hi);
                ncnt_reg[4*i+2] <= clampc(rp_lo);
                ncnt_reg[4*i+3] <= clampc(rp_hi);
            end
        end
        else if (cmd.apply)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cnt_reg[i]  <= adj(cnt_reg[i], d[i]);
                ncnt_reg[i] <= adj(ncnt_reg[i], dn[i]);
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            event_index          <= cmd.none ? 7'd0 : cmd.ev;
            total_rate           <= total_reg;
            no_event             <= cmd.none;
            deme0_counts         <= {lo16(cnt_reg[3]), lo16(cnt_reg[2]),
                                     lo16(cnt_reg[1]), lo16(cnt_reg[0])};
            deme1_counts         <= {lo16(cnt_reg[7]), lo16(cnt_reg[6]),
                                     lo16(cnt_reg[5]), lo16(cnt_reg[4])};
            deme0_neutral_counts <= {lo16(ncnt_reg[3]), lo16(ncnt_reg[2]),
                                     lo16(ncnt_reg[1]), lo16(ncnt_reg[0])};
            deme1_neutral_counts <= {lo16(ncnt_reg[7]), lo16(ncnt_reg[6]),
                                     lo16(ncnt_reg[5]), lo16(ncnt_reg[4])};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/gdes_ctrl.sv -----
`default_nettype none
module gdes_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_req_type,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gdes_pkg::gdes_cmd_t        cmd,
    input  wire gdes_pkg::gdes_stat_t  stat
);
    import gdes_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RST    = 4'd1;
    localparam logic [3:0] S_DSTART = 4'd2;
    localparam logic [3:0] S_DWAIT  = 4'd3;
    localparam logic [3:0] S_RINIT  = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MWAIT  = 4'd6;
    localparam logic [3:0] S_RDONE  = 4'd7;
    localparam logic [3:0] S_TCHK   = 4'd8;
    localparam logic [3:0] S_TSTART = 4'd9;
    localparam logic [3:0] S_TWAIT  = 4'd10;
    localparam logic [3:0] S_APPLY  = 4'd11;
    localparam logic [3:0] S_LOAD   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [3:0] didx_reg, didx_next;
    logic [6:0] ev_reg, ev_next;
    logic [2:0] step_reg, step_next;
    logic       pass_reg, pass_next;
    logic       none_reg, none_next;
    logic       oval_reg, oval_next;
    logic       out_free;

    assign out_free  = !oval_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = oval_reg;

    always_comb
    begin
        state_next = state_reg;
        didx_next  = didx_reg;
        ev_next    = ev_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        none_next  = none_reg;
        oval_next  = (oval_reg && out_ready) ? 1'b0 : oval_reg;
        cmd            = '0;
        cmd.div_idx    = didx_reg;
        cmd.ev         = ev_reg;
        cmd.step       = step_reg;
        cmd.none       = none_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    none_next   = 1'b0;
                    ev_next     = '0;
                    didx_next   = '0;
                    pass_next   = 1'b0;
                    state_next  = (in_req_type == REQ_RESET) ? S_RST : S_DSTART;
                end
            end
            S_RST:
            begin
                cmd.rst_counts = 1'b1;
                state_next     = S_LOAD;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (stat.div_done)
                begin
                    if (didx_reg == 4'(NUM_DIVS - 1))
                    begin
                        ev_next    = '0;
                        state_next = S_RINIT;
                    end
                    else
                    begin
                        didx_next  = didx_reg + 4'd1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_RINIT:
            begin
                cmd.r_init = 1'b1;
                step_next  = '0;
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (stat.mul_done)
                begin
                    if (stat.is_last)
                        state_next = S_RDONE;
                    else
                    begin
                        step_next  = step_reg + 3'd1;
                        state_next = S_MSTART;
                    end
                end
            end
            S_RDONE:
            begin
                if (!pass_reg)
                begin
                    cmd.tot_add = 1'b1;
                    if (ev_reg == 7'(NUM_EVENTS - 1))
                        state_next = S_TCHK;
                    else
                    begin
                        ev_next    = ev_reg + 7'd1;
                        state_next = S_RINIT;
                    end
                end
                else
                begin
                    cmd.run_add = 1'b1;
                    if (stat.hit || ev_reg == 7'(NUM_EVENTS - 1))
                        state_next = S_APPLY;
                    else
                    begin
                        ev_next    = ev_reg + 7'd1;
                        state_next = S_RINIT;
                    end
                end
            end
            S_TCHK:
            begin
                if (stat.total_zero)
                begin
                    none_next  = 1'b1;
                    state_next = S_LOAD;
                end
                else
                    state_next = S_TSTART;
            end
            S_TSTART:
            begin
                cmd.mul_start  = 1'b1;
                cmd.mul_target = 1'b1;
                state_next     = S_TWAIT;
            end
            S_TWAIT:
            begin
                cmd.mul_target = 1'b1;
                if (stat.mul_done)
                begin
                    pass_next  = 1'b1;
                    ev_next    = '0;
                    state_next = S_RINIT;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            didx_reg  <= '0;
            ev_reg    <= '0;
            step_reg  <= '0;
            pass_reg  <= 1'b0;
            none_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            didx_reg  <= didx_next;
            ev_reg    <= ev_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
            none_reg  <= none_next;
            oval_reg  <= oval_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/gillespie_two_deme_event_step.sv -----
`default_nettype none
// Channel  Role   Word
// req      sink   req_type, event_draw, three host and three parasite draws
// rsp      source event_index, total_rate, no_event, four packed count sets
// cfg      sink   register index (0..6) and 64-bit data, always ready
//
// Count reset word: the counts are restored in S_RST and the result is loaded in S_LOAD.
// Event word: 12 frequency divisions on the shared divider, then two passes over the
// 88 rates on the shared 32x32 multiplier, with 1 to 5 multiplies per rate, and then
// the selected event is applied.
// One word in flight; the next is taken once the result is in the output register.
// rst_n clears the registers to their reset values and the counts to 500 each.
module gillespie_two_deme_event_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gdes_in_if.sink   req,
    gdes_out_if.source rsp,
    gdes_cfg_if.sink  cfg
);
    import gdes_pkg::*;

    gdes_cmd_t  cmd;
    gdes_stat_t stat;

    assign cfg.ready = 1'b1;

    gdes_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    gdes_dp #(.CW(COUNT_WIDTH)) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .event_draw           (req.event_draw),
        .host_draw_a          (req.host_draw_a),
        .host_draw_b          (req.host_draw_b),
        .host_draw_c          (req.host_draw_c),
        .parasite_draw_a      (req.parasite_draw_a),
        .parasite_draw_b      (req.parasite_draw_b),
        .parasite_draw_c      (req.parasite_draw_c),
        .cfg_we               (cfg.valid),
        .cfg_index            (cfg.index),
        .cfg_data             (cfg.data),
        .event_index          (rsp.event_index),
        .total_rate           (rsp.total_rate),
        .no_event             (rsp.no_event),
        .deme0_counts         (rsp.deme0_counts),
        .deme1_counts         (rsp.deme1_counts),
        .deme0_neutral_counts (rsp.deme0_neutral_counts),
        .deme1_neutral_counts (rsp.deme1_neutral_counts)
    );
endmodule
`default_nettype wire

// ----- rtl/gdes_chk.sv -----
`default_nettype none
`include "assert_macros.svh"
module gdes_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [6:0]  event_index,
    input wire logic [63:0] total_rate,
    input wire logic        no_event
);
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_SAME(a_none_zero, clk, rst_n, rsp_valid && no_event, total_rate == 64'd0 && event_index == 7'd0)
    `ASSERT_SAME(a_index_range, clk, rst_n, rsp_valid, event_index < 7'd88)
endmodule

bind gillespie_two_deme_event_step gdes_chk u_gdes_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .event_index (rsp.event_index),
    .total_rate  (rsp.total_rate),
    .no_event    (rsp.no_event)
);
`default_nettype wire

// ----- tb/gdes_step_checker.sv -----
`timescale 1ns / 100ps
module gdes_step_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    gdes_in_if        req,
    gdes_out_if       rsp,
    gdes_cfg_if       cfg,
    output int        mismatches,
    output int        outstanding
);
    import gdes_pkg::*;

    typedef struct packed {
        logic [6:0]  ev;
        logic [63:0] total;
        logic        none;
        logic [63:0] d0;
        logic [63:0] d1;
        logic [63:0] n0;
        logic [63:0] n1;
    } step_result_t;

    step_result_t expected_steps[$];

    logic [15:0] host_cap, par_cap, mortality;
    logic [63:0] beta_table;
    logic [31:0] death_c, migr_c, mut_c;
    logic [15:0] cnt[8];
    logic [15:0] neu[8];

    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
    endfunction

    function automatic logic [63:0] frac(logic [15:0] c, logic [15:0] k);
        logic [63:0] kk;
        kk = (k == 0) ? 64'd1 : {48'd0, k};
        return ({48'd0, c} << 16) / kk;
    endfunction

    function automatic logic [63:0] q88(logic [15:0] v);
        return {40'd0, v, 8'd0};
    endfunction

    function automatic logic [63:0] rate_of(int u, int x);
        int a, b, y, i, j;
        logic [63:0] r;
        a = u * 4;
        b = (1 - u) * 4;
        if (x < 4) begin
            r = mul_sat(q88(death_c[15:0]), cnt[a + ((x >> 1) & 1)], 0);
            return mul_sat(r, frac(cnt[a + (x & 1)], host_cap), 16);
        end
        if (x < 8) begin
            y = x - 4;
            r = mul_sat(q88(death_c[31:16]), cnt[a + 2 + ((y >> 1) & 1)], 0);
            return mul_sat(r, frac(cnt[a + 2 + (y & 1)], par_cap), 16);
        end
        if (x < 24) begin
            y = x - 8;
            i = (y >> 3) & 1;
            j = (y >> 2) & 1;
            r = mul_sat(q88(mortality), {48'd0, beta_table[16 * (2 * i + j) +: 16]}, 8);
            r = mul_sat(r, cnt[a + i], 0);
            r = mul_sat(r, cnt[a + 2 + j], 0);
            r = mul_sat(r, frac(cnt[a + ((y >> 1) & 1)], host_cap), 16);
            return mul_sat(r, frac(cnt[a + 2 + (y & 1)], par_cap), 16);
        end
        if (x < 32) begin
            y = x - 24;
            r = mul_sat(q88(migr_c[15:0]), cnt[a + ((y >> 2) & 1)], 0);
            r = mul_sat(r, frac(cnt[a + ((y >> 1) & 1)], host_cap), 16);
            return mul_sat(r, frac(cnt[b + (y & 1)], host_cap), 16);
        end
        if (x < 40) begin
            y = x - 32;
            r = mul_sat(q88(migr_c[31:16]), cnt[a + 2 + ((y >> 2) & 1)], 0);
            r = mul_sat(r, frac(cnt[a + 2 + ((y >> 1) & 1)], par_cap), 16);
            return mul_sat(r, frac(cnt[b + 2 + (y & 1)], par_cap), 16);
        end
        if (x < 42)
            return mul_sat(q88(mut_c[15:0]), cnt[a + ((x - 40) & 1)], 0);
        return mul_sat(q88(mut_c[31:16]), cnt[a + 2 + ((x - 42) & 1)], 0);
    endfunction

    function automatic void bump(ref logic [15:0] arr[8], input int d[8]);
        int v;
        for (int i = 0; i < 8; i++) begin
            v = int'(arr[i]) + d[i];
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            arr[i] = v[15:0];
        end
    endfunction

    function automatic void restore_counts();
        for (int u = 0; u < 2; u++) begin
            cnt[u * 4 + 0] = host_cap / 2;
            cnt[u * 4 + 1] = host_cap - host_cap / 2;
            cnt[u * 4 + 2] = par_cap / 2;
            cnt[u * 4 + 3] = par_cap - par_cap / 2;
        end
        for (int i = 0; i < 8; i++)
            neu[i] = cnt[i];
    endfunction

    function automatic step_result_t predict_step();
        step_result_t res;
        logic [63:0] rates[88];
        logic [63:0] total, target, run;
        int chosen, u, x, a, b, y, t, s;
        int d[8];
        int dn[8];
        logic [63:0] fh, fp, fho, fpo;
        total = 0;
        run = 0;
        chosen = 0;
        res.none = 0;
        for (int i = 0; i < 8; i++) begin
            d[i] = 0;
            dn[i] = 0;
        end
        if (req.req_type == REQ_RESET) begin
            restore_counts();
        end else begin
            for (int e = 0; e < 88; e++) begin
                rates[e] = rate_of(e / 44, e % 44);
                total = ({64{1'b1}} - total < rates[e]) ? {64{1'b1}} : total + rates[e];
            end
            if (total == 0) begin
                res.none = 1;
            end else begin
                target = mul_sat({32'd0, req.event_draw}, total, 32);
                for (int e = 0; e < 88; e++) begin
                    run = ({64{1'b1}} - run < rates[e]) ? {64{1'b1}} : run + rates[e];
                    if (rates[e] != 0 && run >= target) begin
                        chosen = e;
                        break;
                    end
                end
                u = chosen / 44;
                x = chosen % 44;
                a = u * 4;
                b = (1 - u) * 4;
                if (x < 4) begin
                    d[a + ((x >> 1) & 1)]--;
                    d[a + (x & 1)]++;
                end else if (x < 8) begin
                    y = x - 4;
                    d[a + 2 + ((y >> 1) & 1)]--;
                    d[a + 2 + (y & 1)]++;
                end else if (x < 24) begin
                    y = x - 8;
                    d[a + ((y >> 3) & 1)]--;
                    d[a + ((y >> 1) & 1)]++;
                    d[a + 2 + ((y >> 2) & 1)]++;
                    d[a + 2 + (y & 1)]--;
                end else if (x < 40) begin
                    s = (x < 32) ? 0 : 2;
                    y = (x - 24) & 7;
                    t = (y >> 2) & 1;
                    d[a + s + t]--;
                    d[b + s + t]++;
                    d[a + s + ((y >> 1) & 1)]++;
                    d[b + s + (y & 1)]--;
                end else begin
                    s = (x < 42) ? 0 : 2;
                    t = (x - 40) & 1;
                    d[a + s + t]--;
                    d[a + s + (t ^ 1)]++;
                end
                fh = frac(neu[a], host_cap);
                fp = frac(neu[a + 2], par_cap);
                fho = frac(neu[b], host_cap);
                fpo = frac(neu[b + 2], par_cap);
                if (x < 24 && (x < 4 || x >= 8)) begin
                    dn[a + (req.host_draw_a < fh ? 0 : 1)]++;
                    dn[a + (req.host_draw_b < fh ? 0 : 1)]--;
                end
                if (x >= 4 && x < 24) begin
                    dn[a + 2 + (req.parasite_draw_a < fp ? 0 : 1)]++;
                    dn[a + 2 + (req.parasite_draw_b < fp ? 0 : 1)]--;
                end
                if (x >= 24 && x < 32) begin
                    t = req.host_draw_a < fh ? 0 : 1;
                    dn[a + t]--;
                    dn[b + t]++;
                    dn[a + (req.host_draw_b < fh ? 0 : 1)]++;
                    dn[b + (req.host_draw_c < fho ? 0 : 1)]--;
                end else if (x >= 32 && x < 40) begin
                    t = req.parasite_draw_a < fp ? 0 : 1;
                    dn[a + 2 + t]--;
                    dn[b + 2 + t]++;
                    dn[a + 2 + (req.parasite_draw_b < fp ? 0 : 1)]++;
                    dn[b + 2 + (req.parasite_draw_c < fpo ? 0 : 1)]--;
                end else if (x >= 40 && x < 42) begin
                    t = req.host_draw_a < fh ? 0 : 1;
                    dn[a + t]--;
                    dn[a + (t ^ 1)]++;
                end else if (x >= 42) begin
                    t = req.parasite_draw_a < fp ? 0 : 1;
                    dn[a + 2 + t]--;
                    dn[a + 2 + (t ^ 1)]++;
                end
                bump(cnt, d);
                bump(neu, dn);
            end
        end
        res.ev = chosen[6:0];
        res.total = total;
        res.d0 = {cnt[3], cnt[2], cnt[1], cnt[0]};
        res.d1 = {cnt[7], cnt[6], cnt[5], cnt[4]};
        res.n0 = {neu[3], neu[2], neu[1], neu[0]};
        res.n1 = {neu[7], neu[6], neu[5], neu[4]};
        return res;
    endfunction

    task automatic compare(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    assign outstanding = expected_steps.size();

    always @(posedge clk or negedge rst_n) begin
        step_result_t want;
        if (!rst_n) begin
            host_cap = RESET_CAPACITY;
            par_cap = RESET_CAPACITY;
            mortality = 0;
            beta_table = 0;
            death_c = 0;
            migr_c = 0;
            mut_c = 0;
            for (int i = 0; i < 8; i++) begin
                cnt[i] = 16'd500;
                neu[i] = 16'd500;
            end
            expected_steps.delete();
            mismatches = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_steps.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected word expected none actual %h", $time,
                             rsp.total_rate);
                end else begin
                    want = expected_steps.pop_front();
                    compare("event_index", want.ev, rsp.event_index);
                    compare("total_rate", want.total, rsp.total_rate);
                    compare("no_event", want.none, rsp.no_event);
                    compare("deme0_counts", want.d0, rsp.deme0_counts);
                    compare("deme1_counts", want.d1, rsp.deme1_counts);
                    compare("deme0_neutral_counts", want.n0, rsp.deme0_neutral_counts);
                    compare("deme1_neutral_counts", want.n1, rsp.deme1_neutral_counts);
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_HOST_CAP:  host_cap = cfg.data[15:0];
                    CFG_PAR_CAP:   par_cap = cfg.data[15:0];
                    CFG_INFECT:    beta_table = cfg.data;
                    CFG_MORTALITY: mortality = cfg.data[15:0];
                    CFG_DEATH:     death_c = cfg.data[31:0];
                    CFG_MIGRATE:   migr_c = cfg.data[31:0];
                    CFG_MUTATE:    mut_c = cfg.data[31:0];
                    default:       ;
                endcase
            end
            if (req.valid && req.ready)
                expected_steps.push_back(predict_step());
        end
    end
endmodule

// ----- tb/gillespie_two_deme_event_step_test.sv -----
`timescale 1ns / 100ps
module gillespie_two_deme_event_step_test;
    import gdes_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   burst_left;

    gdes_in_if  req_bus ();
    gdes_out_if rsp_bus ();
    gdes_cfg_if cfg_bus ();

    gillespie_two_deme_event_step uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    gdes_step_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .cfg         (cfg_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        int stall_left;
        bit stalling;
        stall_left = 0;
        stalling = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                stalling = ($urandom_range(0, 3) == 0);
                stall_left = stalling ? $urandom_range(1, 30) : $urandom_range(1, 200);
            end
            stall_left--;
            rsp_bus.ready = !stalling;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic send_word(logic kind, logic [31:0] draw, logic [15:0] h, logic [15:0] p);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 40);
            burst_left = $urandom_range(1, 12);
            @(negedge clk);
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        burst_left--;
        req_bus.valid = 1'b1;
        req_bus.req_type = kind;
        req_bus.event_draw = draw;
        req_bus.host_draw_a = h;
        req_bus.host_draw_b = $urandom;
        req_bus.host_draw_c = $urandom;
        req_bus.parasite_draw_a = p;
        req_bus.parasite_draw_b = $urandom;
        req_bus.parasite_draw_c = $urandom;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    task automatic send_random();
        logic kind;
        kind = ($urandom_range(0, 29) == 0) ? REQ_RESET : REQ_EVENT;
        send_word(kind, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        @(negedge clk);
        req_bus.valid = 1'b0;
        burst_left = 0;
        wait (outstanding == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_all(logic [15:0] hc, logic [15:0] pc, logic [63:0] beta,
                           logic [15:0] alpha, logic [31:0] dc, logic [31:0] mg,
                           logic [31:0] mt);
        write_reg(CFG_HOST_CAP, {48'd0, hc});
        write_reg(CFG_PAR_CAP, {48'd0, pc});
        write_reg(CFG_INFECT, beta);
        write_reg(CFG_MORTALITY, {48'd0, alpha});
        write_reg(CFG_DEATH, {32'd0, dc});
        write_reg(CFG_MIGRATE, {32'd0, mg});
        write_reg(CFG_MUTATE, {32'd0, mt});
    endtask

    initial
    begin
        #(200_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        burst_left = 0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_EVENT;
        req_bus.event_draw = 0;
        req_bus.host_draw_a = 0;
        req_bus.host_draw_b = 0;
        req_bus.host_draw_c = 0;
        req_bus.parasite_draw_a = 0;
        req_bus.parasite_draw_b = 0;
        req_bus.parasite_draw_c = 0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_HOST_CAP;
        cfg_bus.data = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero total at reset values
        send_word(REQ_EVENT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_word(REQ_RESET, 32'h0, 16'h0, 16'h0);
        drain();

        set_all(16'd1000, 16'd1000, 64'h0080_0100_0040_0200, 16'h0100,
                32'h0100_0100, 32'h0100_0100, 32'h0100_0100);
        send_word(REQ_EVENT, 32'h0, 16'h0, 16'h0);
        send_word(REQ_EVENT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_word(REQ_EVENT, 32'h8000_0000, 16'h8000, 16'h7FFF);
        for (int i = 0; i < 8; i++)
            send_word(REQ_EVENT, i * 32'h2000_0000 + 32'h0100_0000, $urandom, $urandom);
        drain();

        set_all(16'hFFFF, 16'hFFFF, {64{1'b1}}, 16'hFFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_RESET, 32'h0, 16'h0, 16'h0);
        send_word(REQ_EVENT, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
        send_word(REQ_EVENT, 32'h0, 16'hFFFF, 16'h0);
        drain();

        // zero capacity divides as one
        set_all(16'd0, 16'd0, 64'h0100_0100_0100_0100, 16'h0100,
                32'h0001_0001, 32'h0001_0001, 32'h0001_0001);
        send_word(REQ_EVENT, 32'h4000_0000, 16'h1234, 16'h4321);
        send_word(REQ_RESET, 32'h0, 16'h0, 16'h0);
        send_word(REQ_EVENT, 32'h4000_0000, 16'h1234, 16'h4321);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_all(16'd2, 16'd2, 64'h0100_0100_0100_0100, 16'h0100,
                           32'h0100_0100, 32'h0100_0100, 32'h0080_0080);
                1: set_all(16'd1000, 16'd1000, 64'h0100_0050_0020_0100, 16'h0200,
                           32'h0100_0100, 32'h0040_0040, 32'h0010_0010);
                2: set_all(16'hFFFF, 16'hFFFF, {64{1'b1}}, 16'hFFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: set_all($urandom_range(2, 3000), $urandom_range(2, 3000), {$urandom, $urandom},
                                 $urandom, $urandom, $urandom, $urandom);
            endcase
            send_word(REQ_RESET, $urandom, $urandom, $urandom);
            repeat (115) send_random();
            drain();
        end

        wait (outstanding == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
